// ===== rtl/core/pjsr_pkg.sv =====
package pjsr_pkg;

    localparam int DATA_W        = 32;
    localparam int ACC_W         = 64;
    localparam int FRAC_BITS_DEF = 16;
    localparam int N_IN_WORDS    = 8;
    localparam int S_TDATA_W     = N_IN_WORDS * DATA_W;
    localparam int M_TDATA_W     = DATA_W + ACC_W;

    // configuration port
    localparam int CFG_ADDR_W = 2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DX_SQUARED     = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_INV_DX_SQUARED = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_SOURCE_COEF    = 2'd2;

    localparam logic [DATA_W-1:0] DX_SQUARED_RST     = 32'd65536;
    localparam logic [DATA_W-1:0] INV_DX_SQUARED_RST = 32'd65536;
    localparam logic [DATA_W-1:0] SOURCE_COEF_RST    = 32'd823550;

    // arithmetic widths
    localparam int SUM3_W  = DATA_W + 2;   // sum of three neighbours
    localparam int S_W     = DATA_W + 3;   // sum of six neighbours
    localparam int D_W     = DATA_W + 4;   // S - 6 * centre
    localparam int MUL_A_W = D_W - 1;      // magnitude of S - 6 * centre

    // divide by six, several quotient bits per step
    localparam int DIVIDEND_W = MUL_A_W;
    localparam int DIV_BITS   = 5;
    localparam int DIV_STEPS  = (DIVIDEND_W + DIV_BITS - 1) / DIV_BITS;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam logic [3:0] DIVISOR = 4'd6;

    localparam logic [DATA_W-1:0] SMAX = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SMIN = {1'b1, {(DATA_W-1){1'b0}}};

    typedef enum logic [3:0] {
        OP_NONE,
        OP_LOAD,
        OP_MUL_K,
        OP_KSAT,
        OP_MUL_GAIN,
        OP_MUL_LAP,
        OP_LAP,
        OP_RES,
        OP_RMAG,
        OP_SQ,
        OP_ACC,
        OP_DIV,
        OP_OUT
    } op_t;

    typedef struct packed {
        op_t op;
    } cmd_t;

    typedef struct packed {
        logic out_free;
    } stat_t;

endpackage

// ===== rtl/core/poisson_jacobi_stencil_residual.sv =====
// an input beat walks the load, multiply, residual, square, accumulate, divide
// and output states, one cell at a time; one shared 35x32 multiplier issues five
// products in sequence, then the divide by six retires five quotient bits a cycle
// the output register holds a finished beat while the next cell is taken in
// reset: synchronous, aresetn low; residual sum cleared, config at defaults
module poisson_jacobi_stencil_residual import pjsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // nbr_xm, nbr_xp, nbr_ym, nbr_yp, nbr_zm, nbr_zp, centre_pot, density
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // new_pot, residual_sum_sq
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wr_data
);

    cmd_t  cmd;
    stat_t stat;

    pjsr_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    pjsr_dp #(
        .FRAC_BITS (FRAC_BITS)
    ) u_dp (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cmd         (cmd),
        .stat        (stat),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    // one cell at a time: no second beat right after an accepted one
    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input accepted while a cell is in flight");

    // a finished cell always lands in the output register
    a_out_load: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_OUT && stat.out_free |=> m_tvalid)
        else $error("finished cell not presented");

    // nothing is issued to the datapath while waiting for input
    a_idle_quiet: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tready && !s_tvalid |-> cmd.op == OP_NONE)
        else $error("datapath busy while idle");

endmodule

// ===== rtl/core/pjsr_ctrl.sv =====
module pjsr_ctrl import pjsr_pkg::*; (
    input  logic  aclk,
    input  logic  aresetn,
    input  logic  s_tvalid,
    output logic  s_tready,
    input  stat_t stat,
    output cmd_t  cmd
);

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_K,
        ST_KSAT,
        ST_MUL_GAIN,
        ST_MUL_LAP,
        ST_LAP,
        ST_RES,
        ST_RMAG,
        ST_SQ,
        ST_ACC,
        ST_DIV,
        ST_OUT
    } state_t;

    state_t               state_reg, state_next;
    logic [DIV_CNT_W-1:0] div_cnt_reg, div_cnt_next;

    always_comb begin
        state_next   = state_reg;
        div_cnt_next = div_cnt_reg;
        cmd.op       = OP_NONE;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.op     = OP_LOAD;
                    state_next = ST_MUL_K;
                end
            end
            ST_MUL_K: begin
                cmd.op     = OP_MUL_K;
                state_next = ST_KSAT;
            end
            ST_KSAT: begin
                cmd.op     = OP_KSAT;
                state_next = ST_MUL_GAIN;
            end
            ST_MUL_GAIN: begin
                cmd.op     = OP_MUL_GAIN;
                state_next = ST_MUL_LAP;
            end
            ST_MUL_LAP: begin
                cmd.op     = OP_MUL_LAP;
                state_next = ST_LAP;
            end
            ST_LAP: begin
                cmd.op     = OP_LAP;
                state_next = ST_RES;
            end
            ST_RES: begin
                cmd.op     = OP_RES;
                state_next = ST_RMAG;
            end
            ST_RMAG: begin
                cmd.op     = OP_RMAG;
                state_next = ST_SQ;
            end
            ST_SQ: begin
                cmd.op     = OP_SQ;
                state_next = ST_ACC;
            end
            ST_ACC: begin
                cmd.op       = OP_ACC;
                div_cnt_next = '0;
                state_next   = ST_DIV;
            end
            ST_DIV: begin
                cmd.op       = OP_DIV;
                div_cnt_next = div_cnt_reg + 1'b1;
                if (div_cnt_reg == DIV_CNT_W'(DIV_STEPS - 1)) begin
                    state_next = ST_OUT;
                end
            end
            ST_OUT: begin
                cmd.op = OP_OUT;
                // wait until the output register can take the beat
                if (stat.out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign s_tready = (state_reg == ST_IDLE);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            div_cnt_reg <= '0;
        end else begin
            state_reg   <= state_next;
            div_cnt_reg <= div_cnt_next;
        end
    end

endmodule

// ===== rtl/core/pjsr_dp.sv =====
module pjsr_dp import pjsr_pkg::*; #(
    parameter int FRAC_BITS = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  cmd_t                  cmd,
    output stat_t                 stat,
    input  logic [S_TDATA_W-1:0]  s_tdata,
    input  logic                  s_tlast,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [M_TDATA_W-1:0]  m_tdata,
    output logic                  m_tlast,
    input  logic                  cfg_wr_en,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [DATA_W-1:0]     cfg_wr_data
);

    localparam int PROD_W = MUL_A_W + DATA_W;
    localparam int SH_W   = PROD_W - FRAC_BITS;
    localparam int LAP_W  = SH_W + 1;
    localparam int N_W    = SH_W + 2;
    localparam int R_W    = SH_W + 2;

    // configuration
    logic [DATA_W-1:0] dx_sq_reg, inv_dx_sq_reg, coef_reg;

    // item registers
    logic signed [SUM3_W-1:0] sa_reg, sb_reg;
    logic signed [DATA_W-1:0] centre_reg;
    logic [DATA_W-1:0]        dens_mag_reg;
    logic                     dens_neg_reg;
    logic                     last_reg;

    logic signed [S_W-1:0]  s_reg;
    logic [MUL_A_W-1:0]     d_mag_reg;
    logic                   d_neg_reg;
    logic [DATA_W-1:0]      k_reg;
    logic [SH_W-1:0]        ms_reg, mk_reg;
    logic signed [LAP_W-1:0] lap_reg;
    logic signed [N_W-1:0]  n_reg;
    logic signed [R_W-1:0]  r_reg;
    logic [N_W-1:0]         n_mag_reg;
    logic                   n_neg_reg;
    logic [DATA_W-1:0]      r_mag_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [ACC_W-1:0]       acc_reg;

    logic [DIVIDEND_W-1:0]  qd_reg, qd_next;
    logic [2:0]             rem_reg, rem_next;
    logic                   n_big_reg;

    logic [DATA_W-1:0]      pot_out_reg;
    logic [ACC_W-1:0]       sum_out_reg;
    logic                   last_out_reg;
    logic                   m_tvalid_reg;

    // combinational
    logic signed [DATA_W-1:0] in_w [N_IN_WORDS];
    logic signed [S_W-1:0]    c_ext, six_c;
    logic signed [D_W-1:0]    d_next;
    logic [SH_W-1:0]          prod_sh;
    logic                     k_over;
    logic [DATA_W-1:0]        k_next;
    logic [N_W-1:0]           mk_ext;
    logic signed [N_W-1:0]    n_next;
    logic signed [LAP_W-1:0]  lap_next;
    logic [R_W-1:0]           ms_ext;
    logic signed [R_W-1:0]    r_next;
    logic                     r_pos_sat, r_neg_sat;
    logic [DATA_W-1:0]        r_clamp;
    logic [MUL_A_W-1:0]       mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic                     mul_en;
    logic [ACC_W:0]           acc_sum;
    logic                     q_pos_sat, q_neg_sat;
    logic [DATA_W-1:0]        pot_next;
    logic                     out_free;

    for (genvar i = 0; i < N_IN_WORDS; i++) begin : g_unpack
        assign in_w[i] = s_tdata[i*DATA_W +: DATA_W];
    end

    assign out_free      = !m_tvalid_reg || m_tready;
    assign stat.out_free = out_free;

    // S - 6 * centre, six times centre as two shifts
    assign c_ext  = S_W'(centre_reg);
    assign six_c  = (c_ext <<< 2) + (c_ext <<< 1);
    assign d_next = D_W'(s_reg) - D_W'(six_c);

    assign prod_sh = prod_reg[PROD_W-1:FRAC_BITS];
    assign k_over  = |prod_reg[PROD_W-1:FRAC_BITS+DATA_W];
    assign k_next  = k_over ? '1 : prod_reg[FRAC_BITS+DATA_W-1:FRAC_BITS];

    assign lap_next = d_neg_reg ? -$signed({1'b0, prod_sh}) : $signed({1'b0, prod_sh});

    assign mk_ext = {2'b00, mk_reg};
    assign n_next = N_W'(s_reg) - (dens_neg_reg ? -$signed(mk_ext) : $signed(mk_ext));

    assign ms_ext = {2'b00, ms_reg};
    assign r_next = R_W'(lap_reg) - (dens_neg_reg ? -$signed(ms_ext) : $signed(ms_ext));

    // clamp the residual to the signed word range
    assign r_pos_sat = !r_reg[R_W-1] && (|r_reg[R_W-2:DATA_W-1]);
    assign r_neg_sat = r_reg[R_W-1] && !(&r_reg[R_W-2:DATA_W-1]);
    assign r_clamp   = r_pos_sat ? SMAX : (r_neg_sat ? SMIN : r_reg[DATA_W-1:0]);

    always_comb begin
        mul_en = 1'b1;
        mul_a  = '0;
        mul_b  = '0;
        case (cmd.op)
            OP_MUL_K: begin
                mul_a = MUL_A_W'(dx_sq_reg);
                mul_b = coef_reg;
            end
            OP_KSAT: begin
                mul_a = MUL_A_W'(dens_mag_reg);
                mul_b = coef_reg;
            end
            OP_MUL_GAIN: begin
                mul_a = MUL_A_W'(dens_mag_reg);
                mul_b = k_reg;
            end
            OP_MUL_LAP: begin
                mul_a = d_mag_reg;
                mul_b = inv_dx_sq_reg;
            end
            OP_SQ: begin
                mul_a = MUL_A_W'(r_mag_reg);
                mul_b = r_mag_reg;
            end
            default: begin
                mul_en = 1'b0;
            end
        endcase
    end

    // restoring divide by six, DIV_BITS quotient bits per step
    always_comb begin
        logic [3:0] t;
        qd_next  = qd_reg;
        rem_next = rem_reg;
        for (int j = 0; j < DIV_BITS; j++) begin
            t       = {rem_next, qd_next[DIVIDEND_W-1]};
            qd_next = {qd_next[DIVIDEND_W-2:0], 1'b0};
            if (t >= DIVISOR) begin
                rem_next   = 3'(t - DIVISOR);
                qd_next[0] = 1'b1;
            end else begin
                rem_next = t[2:0];
            end
        end
    end

    assign acc_sum = {1'b0, acc_reg} + {1'b0, prod_reg[ACC_W-1:0]};

    assign q_pos_sat = n_big_reg || (|qd_reg[DIVIDEND_W-1:DATA_W-1]);
    assign q_neg_sat = n_big_reg || (|qd_reg[DIVIDEND_W-1:DATA_W])
                     || (qd_reg[DATA_W-1] && (|qd_reg[DATA_W-2:0]));
    assign pot_next  = n_neg_reg ? (q_neg_sat ? SMIN : -qd_reg[DATA_W-1:0])
                                 : (q_pos_sat ? SMAX : qd_reg[DATA_W-1:0]);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dx_sq_reg     <= DX_SQUARED_RST;
            inv_dx_sq_reg <= INV_DX_SQUARED_RST;
            coef_reg      <= SOURCE_COEF_RST;
        end else if (cfg_wr_en) begin
            case (cfg_addr)
                CFG_DX_SQUARED:     dx_sq_reg     <= cfg_wr_data;
                CFG_INV_DX_SQUARED: inv_dx_sq_reg <= cfg_wr_data;
                CFG_SOURCE_COEF:    coef_reg      <= cfg_wr_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (mul_en) begin
            prod_reg <= PROD_W'(mul_a) * PROD_W'(mul_b);
        end
        case (cmd.op)
            OP_LOAD: begin
                sa_reg       <= SUM3_W'(in_w[0]) + SUM3_W'(in_w[1]) + SUM3_W'(in_w[2]);
                sb_reg       <= SUM3_W'(in_w[3]) + SUM3_W'(in_w[4]) + SUM3_W'(in_w[5]);
                centre_reg   <= in_w[6];
                dens_neg_reg <= in_w[7][DATA_W-1];
                dens_mag_reg <= in_w[7][DATA_W-1] ? -in_w[7] : in_w[7];
                last_reg     <= s_tlast;
            end
            OP_MUL_K: begin
                s_reg <= S_W'(sa_reg) + S_W'(sb_reg);
            end
            OP_KSAT: begin
                k_reg     <= k_next;
                d_neg_reg <= d_next[D_W-1];
                d_mag_reg <= d_next[D_W-1] ? MUL_A_W'(-d_next) : MUL_A_W'(d_next);
            end
            OP_MUL_GAIN: begin
                ms_reg <= prod_sh;
            end
            OP_MUL_LAP: begin
                mk_reg <= prod_sh;
            end
            OP_LAP: begin
                lap_reg <= lap_next;
                n_reg   <= n_next;
            end
            OP_RES: begin
                r_reg     <= r_next;
                n_neg_reg <= n_reg[N_W-1];
                n_mag_reg <= n_reg[N_W-1] ? N_W'(-n_reg) : N_W'(n_reg);
            end
            OP_RMAG: begin
                r_mag_reg <= r_clamp[DATA_W-1] ? -r_clamp : r_clamp;
            end
            OP_ACC: begin
                qd_reg    <= n_mag_reg[DIVIDEND_W-1:0];
                rem_reg   <= '0;
                n_big_reg <= |n_mag_reg[N_W-1:DIVIDEND_W];
            end
            OP_DIV: begin
                qd_reg  <= qd_next;
                rem_reg <= rem_next;
            end
            OP_OUT: begin
                if (out_free) begin
                    pot_out_reg  <= pot_next;
                    sum_out_reg  <= acc_reg;
                    last_out_reg <= last_reg;
                end
            end
            default: ;
        endcase
    end

    // running sum of squared residuals, cleared after the last cell of a sweep, and the output valid flag
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            acc_reg      <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_ACC) begin
                acc_reg <= acc_sum[ACC_W] ? '1 : acc_sum[ACC_W-1:0];
            end else if (cmd.op == OP_OUT && out_free && last_reg) begin
                acc_reg <= '0;
            end
            if (cmd.op == OP_OUT && out_free) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {sum_out_reg, pot_out_reg};
    assign m_tlast  = last_out_reg;

endmodule

// ===== tb/sv/poisson_jacobi_stencil_residual_tb.sv =====
`timescale 1ns / 100ps

module poisson_jacobi_stencil_residual_tb import pjsr_pkg::*;;

    localparam int FRAC_W          = FRAC_BITS_DEF;
    localparam int N_PHASES        = 8;
    localparam int CELLS_PER_PHASE = 104;
    localparam int SETTLE_CYCLES   = 24;    // longer than an accepted cell takes to reach the output
    localparam int QUIET_LIMIT     = 2000;  // far above gap + latency + longest stall

    // index past the last register, the block must ignore it
    localparam logic [CFG_ADDR_W-1:0] CFG_NO_REG = 2'd3;

    localparam logic [DATA_W-1:0] Q_ZERO = 32'h0000_0000;
    localparam logic [DATA_W-1:0] Q_ONE  = 32'h0001_0000;
    localparam logic [DATA_W-1:0] Q_SIX  = 32'h0006_0000;
    localparam logic [DATA_W-1:0] ALL1   = 32'hFFFF_FFFF;

    // first member lands in the top bits, so density is listed first
    typedef struct packed {
        logic signed [31:0] density;
        logic signed [31:0] centre;
        logic signed [31:0] nbr_zp;
        logic signed [31:0] nbr_zm;
        logic signed [31:0] nbr_yp;
        logic signed [31:0] nbr_ym;
        logic signed [31:0] nbr_xp;
        logic signed [31:0] nbr_xm;
    } cell_t;

    typedef struct packed {
        logic [31:0] pot;
        logic [63:0] sum;
        logic        last;
    } update_t;

    typedef struct {
        cell_t   stim;
        logic    last;
        bit      typed;
        update_t want;
    } cell_row_t;

    typedef enum int {CELL_SMOOTH, CELL_WILD, CELL_EDGE, CELL_MIXED} cell_style_t;
    typedef enum int {RX_OPEN, RX_COIN, RX_MOSTLY, RX_SLOW} rx_mode_t;

    logic                  aclk;
    logic                  aresetn;
    logic                  s_tvalid;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata;
    logic                  s_tlast;
    logic                  m_tvalid;
    logic                  m_tready;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  m_tlast;
    logic                  cfg_wr_en;
    logic [CFG_ADDR_W-1:0] cfg_addr;
    logic [DATA_W-1:0]     cfg_wr_data;

    // shadow of the block's registers and sweep accumulator
    logic [31:0] cfg_dx_sq     = DX_SQUARED_RST;
    logic [31:0] cfg_inv_dx_sq = INV_DX_SQUARED_RST;
    logic [31:0] cfg_coef      = SOURCE_COEF_RST;
    logic [63:0] sweep_acc     = '0;

    update_t   due_updates[$];
    cell_row_t directed_rows[$];
    int        err_cnt      = 0;
    int        beats_seen   = 0;
    int        quiet_cycles = 0;

    poisson_jacobi_stencil_residual u_dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_addr    (cfg_addr),
        .cfg_wr_data (cfg_wr_data)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // sign(a) * floor(|a| * b / 2^FRAC_W), exact for |a| < 2^36
    function automatic longint scale_frac(input longint a, input logic [31:0] b);
        logic [63:0]  mag;
        logic [127:0] prod;
        longint       r;
        mag  = (a < 0) ? 64'(-a) : 64'(a);
        prod = {64'd0, mag} * {96'd0, b};
        r    = longint'(prod[FRAC_W+63:FRAC_W]);
        return (a < 0) ? -r : r;
    endfunction

    function automatic longint clamp_s32(input longint v);
        if (v > 64'sd2147483647) return 64'sd2147483647;
        if (v < -64'sd2147483648) return -64'sd2147483648;
        return v;
    endfunction

    // jacobi update plus the squared residual folded into the sweep sum
    function automatic update_t relax_cell(input cell_t c, input logic last);
        longint      nsum;
        longint      n;
        longint      np;
        longint      lap;
        longint      r;
        logic [63:0] gain;
        logic [63:0] mag;
        logic [63:0] sq;
        update_t     u;
        nsum = longint'(c.nbr_xm) + longint'(c.nbr_xp) + longint'(c.nbr_ym)
             + longint'(c.nbr_yp) + longint'(c.nbr_zm) + longint'(c.nbr_zp);
        gain = ({32'd0, cfg_dx_sq} * {32'd0, cfg_coef}) >> FRAC_W;
        if (gain > 64'h0000_0000_FFFF_FFFF) gain = 64'h0000_0000_FFFF_FFFF;
        n   = nsum - scale_frac(longint'(c.density), gain[31:0]);
        np  = clamp_s32(n / 6);
        lap = scale_frac(nsum - 6 * longint'(c.centre), cfg_inv_dx_sq);
        r   = clamp_s32(lap - scale_frac(longint'(c.density), cfg_coef));
        mag = (r < 0) ? 64'(-r) : 64'(r);
        sq  = mag * mag;
        if (sweep_acc > ~sq) sweep_acc = '1;
        else sweep_acc = sweep_acc + sq;
        u.pot  = np[31:0];
        u.sum  = sweep_acc;
        u.last = last;
        if (last) sweep_acc = '0;
        return u;
    endfunction

    function automatic void add_row(input logic [31:0] xm, xp, ym, yp, zm, zp, ctr, dens,
                                    input logic last, input bit typed,
                                    input logic [31:0] pot, input logic [63:0] sum);
        cell_row_t r;
        r.stim.nbr_xm  = xm;
        r.stim.nbr_xp  = xp;
        r.stim.nbr_ym  = ym;
        r.stim.nbr_yp  = yp;
        r.stim.nbr_zm  = zm;
        r.stim.nbr_zp  = zp;
        r.stim.centre  = ctr;
        r.stim.density = dens;
        r.last         = last;
        r.typed        = typed;
        r.want.pot     = pot;
        r.want.sum     = sum;
        r.want.last    = last;
        directed_rows.push_back(r);
    endfunction

    function automatic logic [31:0] pick_word(input cell_style_t style, input int base);
        case (style)
            CELL_SMOOTH: return 32'(base + int'($urandom_range(0, 8191)) - 4096);
            CELL_WILD:   return $urandom;
            CELL_EDGE: begin
                case ($urandom_range(0, 4))
                    0:       return SMIN;
                    1:       return SMAX;
                    2:       return Q_ZERO;
                    3:       return ALL1;
                    default: return 32'd1;
                endcase
            end
            default: begin
                if ($urandom_range(0, 1) == 1) return $urandom;
                return 32'(base + int'($urandom_range(0, 8191)) - 4096);
            end
        endcase
    endfunction

    function automatic cell_t rand_cell();
        cell_style_t style;
        int          base;
        int          pick;
        cell_t       c;
        pick  = $urandom_range(0, 9);
        style = (pick < 6) ? CELL_SMOOTH : (pick < 8) ? CELL_WILD :
                (pick == 8) ? CELL_EDGE : CELL_MIXED;
        base  = int'($urandom_range(0, 2097152)) - 1048576;
        c.nbr_xm = pick_word(style, base);
        c.nbr_xp = pick_word(style, base);
        c.nbr_ym = pick_word(style, base);
        c.nbr_yp = pick_word(style, base);
        c.nbr_zm = pick_word(style, base);
        c.nbr_zp = pick_word(style, base);
        c.centre = pick_word(style, base);
        // smooth cells get a small density so residuals stay moderate
        if (style == CELL_SMOOTH) c.density = 32'(int'($urandom_range(0, 65535)) - 32768);
        else c.density = pick_word(style, 0);
        return c;
    endfunction

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        $display("mismatch at beat %0d: %s got %h want %h", beats_seen, what, got, want);
        err_cnt++;
    endtask

    task automatic send_cell(input cell_t c, input logic last);
        s_tvalid <= 1'b1;
        s_tdata  <= c;
        s_tlast  <= last;
        do @(posedge aclk); while (!s_tready);
    endtask

    // stop sending, let every pending update come back, then let the block settle
    task automatic drain();
        s_tvalid <= 1'b0;
        while (due_updates.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic program_regs(input logic [31:0] dx, input logic [31:0] inv,
                                input logic [31:0] coef);
        cfg_wr_en   <= 1'b1;
        cfg_addr    <= CFG_DX_SQUARED;
        cfg_wr_data <= dx;
        @(posedge aclk);
        cfg_addr    <= CFG_INV_DX_SQUARED;
        cfg_wr_data <= inv;
        @(posedge aclk);
        cfg_addr    <= CFG_SOURCE_COEF;
        cfg_wr_data <= coef;
        @(posedge aclk);
        cfg_addr    <= CFG_NO_REG;
        cfg_wr_data <= $urandom;
        @(posedge aclk);
        cfg_wr_en   <= 1'b0;
        cfg_dx_sq     = dx;
        cfg_inv_dx_sq = inv;
        cfg_coef      = coef;
    endtask

    // result side: stretches of always-ready, coin flips, rare stalls and a slow drip
    initial begin
        rx_mode_t mode;
        int       run_left;
        int       tick;
        m_tready <= 1'b0;
        mode     = RX_OPEN;
        run_left = 0;
        tick     = 0;
        forever begin
            @(posedge aclk);
            if (run_left == 0) begin
                mode     = rx_mode_t'($urandom_range(0, 3));
                run_left = $urandom_range(16, 200);
            end
            run_left--;
            tick++;
            case (mode)
                RX_OPEN:   m_tready <= 1'b1;
                RX_COIN:   m_tready <= 1'($urandom_range(0, 1));
                RX_MOSTLY: m_tready <= ($urandom_range(0, 7) != 0);
                default:   m_tready <= (tick % 24 == 0);
            endcase
        end
    end

    always @(posedge aclk) begin
        update_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_updates.size() == 0) begin
                report_mismatch("beat with nothing pending", m_tdata[95:32], '0);
            end else begin
                want = due_updates.pop_front();
                if (m_tdata[31:0] !== want.pot)
                    report_mismatch("new_pot", 64'(m_tdata[31:0]), 64'(want.pot));
                if (m_tdata[95:32] !== want.sum)
                    report_mismatch("residual_sum_sq", m_tdata[95:32], want.sum);
                if (m_tlast !== want.last)
                    report_mismatch("last_out", 64'(m_tlast), 64'(want.last));
            end
            beats_seen++;
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
    end

    initial begin
        while (quiet_cycles < QUIET_LIMIT) @(posedge aclk);
        $display("Testbench completed WITH ERRORS");
        $finish;
    end

    initial begin
        cell_t   c;
        update_t u;
        logic    last;
        int      burst_left;
        int      sweep_left;
        aresetn     <= 1'b0;
        s_tvalid    <= 1'b0;
        s_tdata     <= '0;
        s_tlast     <= 1'b0;
        cfg_wr_en   <= 1'b0;
        cfg_addr    <= CFG_DX_SQUARED;
        cfg_wr_data <= '0;

        // rows with a typed result use the reset register values
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                1'b0, 1'b1, Q_ZERO, 64'd0);
        add_row(Q_SIX, Q_SIX, Q_SIX, Q_SIX, Q_SIX, Q_SIX, Q_SIX, Q_ZERO,
                1'b0, 1'b1, Q_SIX, 64'd0);
        add_row(Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ONE, Q_ZERO, Q_ZERO,
                1'b1, 1'b1, Q_ONE, 64'h0000_0024_0000_0000);
        // potential sits at the word limit and residual clips, high then low
        add_row(SMAX, SMAX, SMAX, SMAX, SMAX, SMAX, SMIN, Q_ZERO,
                1'b1, 1'b1, SMAX, 64'h3FFF_FFFF_0000_0001);
        add_row(SMIN, SMIN, SMIN, SMIN, SMIN, SMIN, SMAX, Q_ZERO,
                1'b1, 1'b1, SMIN, 64'h4000_0000_0000_0000);
        // density extremes walk the sum up to its ceiling
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, SMAX,
                1'b0, 1'b1, SMIN, 64'h4000_0000_0000_0000);
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, SMIN,
                1'b0, 1'b1, SMAX, 64'h7FFF_FFFF_0000_0001);
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, SMAX,
                1'b0, 1'b1, SMIN, 64'hBFFF_FFFF_0000_0001);
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, SMAX,
                1'b0, 1'b1, SMIN, 64'hFFFF_FFFF_0000_0001);
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, SMAX,
                1'b0, 1'b1, SMIN, 64'hFFFF_FFFF_FFFF_FFFF);
        add_row(Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                1'b1, 1'b1, Q_ZERO, 64'hFFFF_FFFF_FFFF_FFFF);
        // negative quotient truncates toward zero
        add_row(32'hFFFF_FFF9, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO, Q_ZERO,
                1'b1, 1'b1, ALL1, 64'd49);
        add_row(32'h1234_5678, 32'hFF01_2346, 32'h0003_0000, 32'hFFFD_8000,
                32'h7FFF_0000, 32'h8001_0000, 32'h0001_1111, 32'h0000_0800,
                1'b0, 1'b0, Q_ZERO, 64'd0);
        add_row(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555,
                1'b0, 1'b0, Q_ZERO, 64'd0);
        add_row(32'h0002_8000, 32'h0002_7000, 32'h0002_9000, 32'h0002_8800,
                32'h0002_7800, 32'h0002_8400, 32'h0002_6666, 32'hFFFF_F000,
                1'b1, 1'b0, Q_ZERO, 64'd0);
        add_row(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1,
                1'b0, 1'b0, Q_ZERO, 64'd0);
        add_row(ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1, ALL1,
                1'b1, 1'b0, Q_ZERO, 64'd0);

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        foreach (directed_rows[i]) begin
            send_cell(directed_rows[i].stim, directed_rows[i].last);
            u = relax_cell(directed_rows[i].stim, directed_rows[i].last);
            due_updates.push_back(directed_rows[i].typed ? directed_rows[i].want : u);
        end
        drain();

        burst_left = $urandom_range(1, 40);
        sweep_left = 0;
        for (int phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: program_regs(32'h0000_0010, 32'h1000_0000, SOURCE_COEF_RST);
                1: program_regs(ALL1, ALL1, ALL1);
                2: program_regs(Q_ZERO, Q_ZERO, Q_ZERO);
                3: program_regs(Q_ONE, Q_ONE, 32'd29491);
                4: program_regs($urandom, $urandom, $urandom);
                5: program_regs(ALL1, Q_ZERO, 32'd1);
                6: program_regs($urandom_range(1, 32'h2_0000), $urandom_range(1, 32'h20_0000),
                                $urandom_range(0, 32'h10_0000));
                default: program_regs(DX_SQUARED_RST, INV_DX_SQUARED_RST, SOURCE_COEF_RST);
            endcase
            for (int i = 0; i < CELLS_PER_PHASE; i++) begin
                if (sweep_left == 0) sweep_left = $urandom_range(1, 48);
                sweep_left--;
                c = rand_cell();
                // mostly proper sweeps, now and then a stray end marker
                last = (sweep_left == 0) || ($urandom_range(0, 31) == 0);
                send_cell(c, last);
                due_updates.push_back(relax_cell(c, last));
                burst_left--;
                if (burst_left == 0) begin
                    s_tvalid <= 1'b0;
                    repeat ($urandom_range(1, 30)) @(posedge aclk);
                    burst_left = ($urandom_range(0, 7) == 0) ? 150 : $urandom_range(1, 40);
                end else if ($urandom_range(0, 199) == 0) begin
                    drain();
                end
            end
            drain();
        end

        if (err_cnt == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/core/pjsr_pkg.sv
rtl/core/pjsr_ctrl.sv
rtl/core/pjsr_dp.sv
rtl/core/poisson_jacobi_stencil_residual.sv
tb/sv/poisson_jacobi_stencil_residual_tb.sv
